FILE: rtl/saa_pkg.sv
`default_nettype none

package saa_pkg;

  localparam int unsigned FIELD_W        = 13;
  localparam int unsigned SUM_W          = FIELD_W + 1;
  localparam int unsigned NUM_CLASS_REGS = 4;
  localparam int unsigned CLS_W          = 2;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned REG_IDX_W      = 3;

  localparam logic [REG_IDX_W-1:0] REG_ATLAS_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ATLAS_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CLASS_H0     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CLASS_H1     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CLASS_H2     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CLASS_H3     = 3'd5;

  localparam logic [FIELD_W-1:0] RST_ATLAS_WIDTH  = 13'd1024;
  localparam logic [FIELD_W-1:0] RST_ATLAS_HEIGHT = 13'd1024;
  localparam logic [FIELD_W-1:0] RST_CLASS_H0     = 13'd16;
  localparam logic [FIELD_W-1:0] RST_CLASS_H1     = 13'd32;
  localparam logic [FIELD_W-1:0] RST_CLASS_H2     = 13'd64;
  localparam logic [FIELD_W-1:0] RST_CLASS_H3     = 13'd128;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_HEIGHT = 2'd1,
    ST_WIDTH  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef logic [FIELD_W-1:0] class_heights_t [NUM_CLASS_REGS];

  // classified request, handed from front to back
  typedef struct packed {
    logic [CLS_W-1:0]   cls;
    logic [FIELD_W-1:0] class_h;
    logic [SUM_W-1:0]   sum;
    logic [FIELD_W-1:0] height;
    status_e            status;
  } req_t;

endpackage

`default_nettype wire

FILE: rtl/saa_front.sv
`default_nettype none

module saa_front #(
  parameter int unsigned NUM_CLASSES = 4,
  parameter int unsigned MAX_DIM     = 4096,
  localparam int unsigned DIM_W      = $clog2(MAX_DIM + 1)
) (
  input  wire logic [saa_pkg::FIELD_W-1:0] tex_width_i,
  input  wire logic [saa_pkg::FIELD_W-1:0] tex_height_i,
  input  wire logic [saa_pkg::FIELD_W-1:0] repeat_width_i,
  input  wire saa_pkg::class_heights_t     class_h_i,
  input  wire logic [DIM_W-1:0]            atlas_w_i,
  output saa_pkg::req_t                    req_o
);

  localparam int unsigned NREG  = (NUM_CLASSES < saa_pkg::NUM_CLASS_REGS) ?
                                  NUM_CLASSES : saa_pkg::NUM_CLASS_REGS;
  localparam int unsigned CMP_W = ((DIM_W > saa_pkg::SUM_W) ? DIM_W : saa_pkg::SUM_W) + 1;

  logic                         found;
  logic [saa_pkg::CLS_W-1:0]    cls;
  logic [saa_pkg::FIELD_W-1:0]  ch;
  logic [saa_pkg::SUM_W-1:0]    sum;

  assign sum = saa_pkg::SUM_W'(tex_width_i) + saa_pkg::SUM_W'(repeat_width_i);

  // first class in index order that is tall enough
  always_comb begin
    found = 1'b0;
    cls   = '0;
    ch    = '0;
    for (int i = 0; i < NREG; i++) begin
      if (!found && (tex_height_i <= class_h_i[i])) begin
        found = 1'b1;
        cls   = saa_pkg::CLS_W'(i);
        ch    = class_h_i[i];
      end
    end
  end

  always_comb begin
    req_o.cls     = cls;
    req_o.class_h = ch;
    req_o.sum     = sum;
    req_o.height  = tex_height_i;
    if (!found) begin
      req_o.status = saa_pkg::ST_HEIGHT;
    end else if (CMP_W'(sum) > CMP_W'(atlas_w_i)) begin
      req_o.status = saa_pkg::ST_WIDTH;
    end else begin
      req_o.status = saa_pkg::ST_OK;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/saa_queue.sv
`default_nettype none

module saa_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire saa_pkg::req_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output saa_pkg::req_t      pop_data_o
);

  localparam int unsigned DEPTH = saa_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  saa_pkg::req_t     mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count above depth");
`endif

endmodule

`default_nettype wire

FILE: rtl/saa_back.sv
`default_nettype none

module saa_back #(
  parameter int unsigned NUM_CLASSES = 4,
  parameter int unsigned MAX_DIM     = 4096,
  localparam int unsigned DIM_W      = $clog2(MAX_DIM + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        req_valid_i,
  input  wire saa_pkg::req_t               req_i,
  output logic                             req_pop_o,
  input  wire logic [DIM_W-1:0]            atlas_w_i,
  input  wire logic [DIM_W-1:0]            atlas_h_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [saa_pkg::FIELD_W-1:0]      pos_x_o,
  output logic [saa_pkg::FIELD_W-1:0]      pos_y_o,
  output logic [saa_pkg::FIELD_W-1:0]      placed_width_o,
  output logic [saa_pkg::FIELD_W-1:0]      placed_height_o,
  output saa_pkg::status_e                 status_o
);

  localparam int unsigned CIDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned CMP_W  = ((DIM_W > saa_pkg::SUM_W) ? DIM_W : saa_pkg::SUM_W) + 1;

  logic [DIM_W-1:0] shelf_x_q [NUM_CLASSES];
  logic [DIM_W-1:0] shelf_y_q [NUM_CLASSES];
  logic [DIM_W-1:0] fill_y_q, fill_y_d;

  logic                       out_valid_q;
  logic [saa_pkg::FIELD_W-1:0] pos_x_q, pos_x_d;
  logic [saa_pkg::FIELD_W-1:0] pos_y_q, pos_y_d;
  logic [saa_pkg::FIELD_W-1:0] pw_q, pw_d;
  logic [saa_pkg::FIELD_W-1:0] ph_q, ph_d;
  saa_pkg::status_e            status_q, status_d;

  logic [CIDX_W-1:0] idx;
  logic [DIM_W-1:0]  cur_x, cur_y, px, py;
  logic              new_shelf, no_room, place;

  assign req_pop_o = req_valid_i && (!out_valid_q || out_ready_i);
  assign idx       = CIDX_W'(req_i.cls);
  assign cur_x     = shelf_x_q[idx];
  assign cur_y     = shelf_y_q[idx];

  // shelf too short for this item: try to open a new one at the fill line
  assign new_shelf = (CMP_W'(cur_x) + CMP_W'(req_i.sum)) > CMP_W'(atlas_w_i);
  assign no_room   = (CMP_W'(fill_y_q) + CMP_W'(req_i.class_h)) > CMP_W'(atlas_h_i);
  assign place     = (req_i.status == saa_pkg::ST_OK) && !(new_shelf && no_room);
  assign px        = new_shelf ? '0 : cur_x;
  assign py        = new_shelf ? fill_y_q : cur_y;
  assign fill_y_d  = DIM_W'(CMP_W'(fill_y_q) + CMP_W'(req_i.class_h));

  always_comb begin
    pos_x_d  = '0;
    pos_y_d  = '0;
    pw_d     = '0;
    ph_d     = '0;
    status_d = req_i.status;
    if (place) begin
      pos_x_d = saa_pkg::FIELD_W'(px);
      pos_y_d = saa_pkg::FIELD_W'(py);
      pw_d    = saa_pkg::FIELD_W'(req_i.sum);
      ph_d    = req_i.height;
    end else if (req_i.status == saa_pkg::ST_OK) begin
      status_d = saa_pkg::ST_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      fill_y_q    <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        shelf_x_q[i] <= DIM_W'(MAX_DIM);
        shelf_y_q[i] <= '0;
      end
    end else begin
      if (req_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (req_pop_o && place) begin
        shelf_x_q[idx] <= DIM_W'(CMP_W'(px) + CMP_W'(req_i.sum));
        if (new_shelf) begin
          shelf_y_q[idx] <= fill_y_q;
          fill_y_q       <= fill_y_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_pop_o) begin
      pos_x_q  <= pos_x_d;
      pos_y_q  <= pos_y_d;
      pw_q     <= pw_d;
      ph_q     <= ph_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pos_x_o         = pos_x_q;
  assign pos_y_o         = pos_y_q;
  assign placed_width_o  = pw_q;
  assign placed_height_o = ph_q;
  assign status_o        = status_q;

`ifndef ASSERT_OFF
  a_fill_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_y_q >= $past(fill_y_q))
    else $error("fill line moved down");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q != saa_pkg::ST_OK) |->
      (pos_x_q == '0) && (pos_y_q == '0) && (pw_q == '0) && (ph_q == '0))
    else $error("error result carries a placement");

  a_error_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_pop_o && !place |=> $stable(fill_y_q))
    else $error("rejected item changed the fill line");
`endif

endmodule

`default_nettype wire

FILE: rtl/shelf_atlas_allocator_core.sv
// Shelf-packing rectangle allocator for a 2D atlas.
// Input channel (in_valid_i/in_ready_o) takes one request: tex_width_i,
// tex_height_i and repeat_width_i. Output channel (out_valid_o/out_ready_i)
// returns one result per request: pos_x_o, pos_y_o, placed_width_o,
// placed_height_o and status_o (ok, height out of range, too wide, atlas full).
// A request is classified on acceptance (height class, width check) and
// written into a two-entry queue; the placement unit pops it and registers
// the result. One request per cycle is sustained while out_ready_i is high,
// as the placement unit looks up and updates a shelf combinationally in
// the cycle it pops a request.
// A stalled output holds its result; the queue keeps taking requests until
// it is full, then in_ready_o drops.
// Reset empties the queue and the result register, marks every shelf full,
// clears the fill line and loads the default atlas and class sizes.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) are registered
// and are meant for idle periods only.
`default_nettype none

module shelf_atlas_allocator_core #(
  parameter int unsigned NUM_CLASSES = 4,
  parameter int unsigned MAX_DIM     = 4096
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [saa_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  wire logic [saa_pkg::FIELD_W-1:0]   cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [saa_pkg::FIELD_W-1:0]   tex_width_i,
  input  wire logic [saa_pkg::FIELD_W-1:0]   tex_height_i,
  input  wire logic [saa_pkg::FIELD_W-1:0]   repeat_width_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [saa_pkg::FIELD_W-1:0]        pos_x_o,
  output logic [saa_pkg::FIELD_W-1:0]        pos_y_o,
  output logic [saa_pkg::FIELD_W-1:0]        placed_width_o,
  output logic [saa_pkg::FIELD_W-1:0]        placed_height_o,
  output logic [1:0]                         status_o
);

  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);

  logic [saa_pkg::FIELD_W-1:0] atlas_w_q, atlas_h_q;
  saa_pkg::class_heights_t     class_h_q;
  logic [DIM_W-1:0]            atlas_w_sat, atlas_h_sat;

  saa_pkg::req_t    front_req, queue_req;
  logic             queue_full, queue_valid, queue_pop;
  saa_pkg::status_e status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_w_q    <= saa_pkg::RST_ATLAS_WIDTH;
      atlas_h_q    <= saa_pkg::RST_ATLAS_HEIGHT;
      class_h_q[0] <= saa_pkg::RST_CLASS_H0;
      class_h_q[1] <= saa_pkg::RST_CLASS_H1;
      class_h_q[2] <= saa_pkg::RST_CLASS_H2;
      class_h_q[3] <= saa_pkg::RST_CLASS_H3;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        saa_pkg::REG_ATLAS_WIDTH:  atlas_w_q    <= cfg_data_i;
        saa_pkg::REG_ATLAS_HEIGHT: atlas_h_q    <= cfg_data_i;
        saa_pkg::REG_CLASS_H0:     class_h_q[0] <= cfg_data_i;
        saa_pkg::REG_CLASS_H1:     class_h_q[1] <= cfg_data_i;
        saa_pkg::REG_CLASS_H2:     class_h_q[2] <= cfg_data_i;
        saa_pkg::REG_CLASS_H3:     class_h_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // atlas size clamps to the largest supported dimension
  assign atlas_w_sat = (32'(atlas_w_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(atlas_w_q);
  assign atlas_h_sat = (32'(atlas_h_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(atlas_h_q);

  assign in_ready_o = !queue_full;

  saa_front #(
    .NUM_CLASSES (NUM_CLASSES),
    .MAX_DIM     (MAX_DIM)
  ) u_front (
    .tex_width_i    (tex_width_i),
    .tex_height_i   (tex_height_i),
    .repeat_width_i (repeat_width_i),
    .class_h_i      (class_h_q),
    .atlas_w_i      (atlas_w_sat),
    .req_o          (front_req)
  );

  saa_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_req),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .pop_data_o  (queue_req)
  );

  saa_back #(
    .NUM_CLASSES (NUM_CLASSES),
    .MAX_DIM     (MAX_DIM)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (queue_valid),
    .req_i           (queue_req),
    .req_pop_o       (queue_pop),
    .atlas_w_i       (atlas_w_sat),
    .atlas_h_i       (atlas_h_sat),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pos_x_o         (pos_x_o),
    .pos_y_o         (pos_y_o),
    .placed_width_o  (placed_width_o),
    .placed_height_o (placed_height_o),
    .status_o        (status)
  );

  assign status_o = status;

endmodule

`default_nettype wire
